[hdl/tile_map_box_collision_resolve_unit_defines.svh]
// Assertion macros for the tile map box collision resolve unit.
// Used by the checker file only; expects clk and rst_n in scope.
`ifndef TILE_MAP_BOX_COLLISION_RESOLVE_UNIT_DEFINES_SVH
`define TILE_MAP_BOX_COLLISION_RESOLVE_UNIT_DEFINES_SVH

// cond in one cycle implies nxt in the next, masked while in reset
`define TMBCR_ASSERT_NEXT(label, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error(msg);

// full property, no reset masking
`define TMBCR_ASSERT_PLAIN(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/tmbcr_pkg.sv]
// Package for the tile map box collision resolve unit: constants, payload
// and job types. No dependencies.
`default_nettype none

package tmbcr_pkg;

  // geometry, pixels
  localparam int TILE_SIZE  = 64;
  localparam int BOX_SIZE   = 60;
  localparam int BOX_HALF   = 30;
  localparam int FRAC_BITS  = 8;

  // geometry in fixed-point units
  localparam int TILE_SHIFT  = $clog2(TILE_SIZE) + FRAC_BITS;
  localparam int BOX_Q       = BOX_SIZE << FRAC_BITS;
  localparam int BOX_HALF_Q  = BOX_HALF << FRAC_BITS;
  localparam int TILE_HALF_Q = TILE_SIZE << (FRAC_BITS - 1);
  localparam int MIN_DIST_Q  = BOX_HALF_Q + TILE_HALF_Q;

  // widths
  localparam int POS_W     = 24;  // port positions
  localparam int WPOS_W    = 26;  // positions during pushes
  localparam int DIFF_W    = 28;  // offset from tile center
  localparam int DIST_W    = 15;  // holds MIN_DIST_Q
  localparam int IDX_W     = 10;  // tile index inside the map
  localparam int CIDX_W    = 12;  // signed corner tile index
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic signed [WPOS_W-1:0] WPOS_MAX = WPOS_W'(2**(POS_W-1) - 1);
  localparam logic signed [WPOS_W-1:0] WPOS_MIN = WPOS_W'(-(2**(POS_W-1)));

  localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

  // item modes
  localparam logic MODE_WRITE   = 1'b0;
  localparam logic MODE_RESOLVE = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic [6:0]              tile_col;
    logic [6:0]              tile_row;
    logic                    tile_solid;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } tmbcr_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] new_x;
    logic signed [POS_W-1:0] new_y;
    logic                    collided;
  } tmbcr_out_t;

  // classified resolve job, corners in order TL, TR, BL, BR
  typedef struct packed {
    logic [3:0]              solid;
    logic [3:0][IDX_W-1:0]   col;
    logic [3:0][IDX_W-1:0]   row;
    logic signed [WPOS_W-1:0] px;
    logic signed [WPOS_W-1:0] py;
  } tmbcr_job_t;

endpackage

`default_nettype wire

[hdl/tmbcr_fifo.sv]
// Small register FIFO used between front and back and on the result side.
// Depends on nothing; payload type is a parameter.
`default_nettype none

module tmbcr_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  T     wr_data,
  output logic can_take,
  input  logic rd_en,
  output logic empty,
  output T     rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  T               mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]    count_r, count_nxt;

  assign can_take = (count_r < (PW+1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({wr_en, rd_en})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

[hdl/tmbcr_front.sv]
// Front end: accepts transactions, holds the map registers and the banked
// solidity map, classifies the four corners. Depends on tmbcr_pkg.
`default_nettype none

module tmbcr_front #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 128
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  tmbcr_pkg::tmbcr_in_t                in_data,
  input  logic                                cfg_we,
  input  logic [tmbcr_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [tmbcr_pkg::CFG_W-1:0]         cfg_data,
  output logic                                job_valid,
  output tmbcr_pkg::tmbcr_job_t               job,
  input  logic                                job_ready
);

  localparam int IDX_W      = tmbcr_pkg::IDX_W;
  localparam int CIDX_W     = tmbcr_pkg::CIDX_W;
  localparam int LIM_W      = IDX_W + 1;
  localparam int BANK_COLS  = (MAX_COLS + 1) / 2;
  localparam int BANK_ROWS  = (MAX_ROWS + 1) / 2;
  localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
  localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  localparam logic [LIM_W-1:0] COL_LIM = LIM_W'(MAX_COLS);
  localparam logic [LIM_W-1:0] ROW_LIM = LIM_W'(MAX_ROWS);

  // 2x2 parity banking: bank {row[0], col[0]} holds every tile of that parity
  function automatic logic [AW-1:0] bank_addr(input logic [IDX_W-1:0] col,
                                              input logic [IDX_W-1:0] row);
    logic [IDX_W-1:0] hc;
    logic [IDX_W-1:0] hr;
    hc = col >> 1;
    hr = row >> 1;
    return AW'(hr * BANK_COLS + hc);
  endfunction

  logic [tmbcr_pkg::CFG_W-1:0] map_cols_r, map_rows_r;
  logic [LIM_W-1:0]            cols_eff, rows_eff;

  logic en_f, acc, acc_wr, acc_rd;

  logic signed [tmbcr_pkg::POS_W:0] cx0, cx1, cy0, cy1, sx0, sx1, sy0, sy1;
  logic [CIDX_W-1:0]        c0, c1, r0, r1, c0p1, r0p1;
  logic [3:0][CIDX_W-1:0]   ck, rk;
  logic [3:0]               inmap;
  logic [1:0][CIDX_W-1:0]   bcol, brow;
  logic [1:0][IDX_W-1:0]    bcol_u, brow_u;
  logic [3:0][AW-1:0]       raddr;
  logic                     wok;
  logic [AW-1:0]            waddr;
  logic [1:0]               wbank;
  logic [3:0]               rd_bits;

  logic                                  s1_valid_r;
  logic [3:0]                            s1_inmap_r;
  logic [3:0][1:0]                       s1_bank_r;
  logic [3:0][IDX_W-1:0]                 s1_col_r, s1_row_r;
  logic signed [tmbcr_pkg::POS_W-1:0]    s1_px_r, s1_py_r;

  assign en_f   = !s1_valid_r || job_ready;
  assign full   = !en_f;
  assign acc    = push && !full;
  assign acc_wr = acc && (in_data.mode == tmbcr_pkg::MODE_WRITE);
  assign acc_rd = acc && (in_data.mode == tmbcr_pkg::MODE_RESOLVE);

  assign cols_eff = (LIM_W'(map_cols_r) > COL_LIM) ? COL_LIM : LIM_W'(map_cols_r);
  assign rows_eff = (LIM_W'(map_rows_r) > ROW_LIM) ? ROW_LIM : LIM_W'(map_rows_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_cols_r <= tmbcr_pkg::CFG_RESET;
      map_rows_r <= tmbcr_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        tmbcr_pkg::CFG_MAP_COLS: map_cols_r <= cfg_data;
        tmbcr_pkg::CFG_MAP_ROWS: map_rows_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // corner tiles: floor by arithmetic shift
  always_comb begin
    cx0  = {in_data.pos_x[tmbcr_pkg::POS_W-1], in_data.pos_x};
    cy0  = {in_data.pos_y[tmbcr_pkg::POS_W-1], in_data.pos_y};
    cx1  = cx0 + (tmbcr_pkg::POS_W+1)'(tmbcr_pkg::BOX_Q);
    cy1  = cy0 + (tmbcr_pkg::POS_W+1)'(tmbcr_pkg::BOX_Q);
    sx0  = cx0 >>> tmbcr_pkg::TILE_SHIFT;
    sx1  = cx1 >>> tmbcr_pkg::TILE_SHIFT;
    sy0  = cy0 >>> tmbcr_pkg::TILE_SHIFT;
    sy1  = cy1 >>> tmbcr_pkg::TILE_SHIFT;
    c0   = sx0[CIDX_W-1:0];
    c1   = sx1[CIDX_W-1:0];
    r0   = sy0[CIDX_W-1:0];
    r1   = sy1[CIDX_W-1:0];
    c0p1 = c0 + 1'b1;
    r0p1 = r0 + 1'b1;

    for (int k = 0; k < 4; k++) begin
      ck[k]    = k[0] ? c1 : c0;
      rk[k]    = k[1] ? r1 : r0;
      inmap[k] = !ck[k][CIDX_W-1] && (ck[k][LIM_W-1:0] < cols_eff) &&
                 !rk[k][CIDX_W-1] && (rk[k][LIM_W-1:0] < rows_eff);
    end

    // the 2x2 block at (c0, r0) touches each bank once
    for (int p = 0; p < 2; p++) begin
      bcol[p]   = (c0[0] == p[0]) ? c0 : c0p1;
      brow[p]   = (r0[0] == p[0]) ? r0 : r0p1;
      bcol_u[p] = (!bcol[p][CIDX_W-1] && (bcol[p][LIM_W-1:0] < COL_LIM)) ?
                  bcol[p][IDX_W-1:0] : '0;
      brow_u[p] = (!brow[p][CIDX_W-1] && (brow[p][LIM_W-1:0] < ROW_LIM)) ?
                  brow[p][IDX_W-1:0] : '0;
    end
    for (int b = 0; b < 4; b++) begin
      raddr[b] = bank_addr(bcol_u[b[0]], brow_u[b[1]]);
    end

    wok   = (LIM_W'(in_data.tile_col) < COL_LIM) && (LIM_W'(in_data.tile_row) < ROW_LIM);
    waddr = bank_addr(IDX_W'(in_data.tile_col), IDX_W'(in_data.tile_row));
    wbank = {in_data.tile_row[0], in_data.tile_col[0]};
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic mem [BANK_DEPTH];
    logic bank_rd_r;

    always_ff @(posedge clk) begin
      if (acc_wr && wok && (wbank == 2'(b))) begin
        mem[waddr] <= in_data.tile_solid;
      end
      if (acc_rd) begin
        bank_rd_r <= mem[raddr[b]];
      end
    end

    assign rd_bits[b] = bank_rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en_f) begin
      s1_valid_r <= acc_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_rd) begin
      s1_inmap_r <= inmap;
      s1_px_r    <= in_data.pos_x;
      s1_py_r    <= in_data.pos_y;
      for (int k = 0; k < 4; k++) begin
        s1_bank_r[k] <= {rk[k][0], ck[k][0]};
        s1_col_r[k]  <= ck[k][IDX_W-1:0];
        s1_row_r[k]  <= rk[k][IDX_W-1:0];
      end
    end
  end

  assign job_valid = s1_valid_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      job.solid[k] = s1_inmap_r[k] && rd_bits[s1_bank_r[k]];
    end
    job.col = s1_col_r;
    job.row = s1_row_r;
    job.px  = tmbcr_pkg::WPOS_W'(s1_px_r);
    job.py  = tmbcr_pkg::WPOS_W'(s1_py_r);
  end

endmodule

`default_nettype wire

[hdl/tmbcr_push.sv]
// One push-out step against corner K, three register stages.
// Depends on tmbcr_pkg.
`default_nettype none

module tmbcr_push #(
  parameter int K = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  tmbcr_pkg::tmbcr_job_t in_job,
  output logic                  out_valid,
  output tmbcr_pkg::tmbcr_job_t out_job
);

  localparam int DIFF_W = tmbcr_pkg::DIFF_W;
  localparam int WPOS_W = tmbcr_pkg::WPOS_W;
  localparam int DIST_W = tmbcr_pkg::DIST_W;

  localparam logic signed [DIFF_W-1:0] DX_OFS =
    DIFF_W'(tmbcr_pkg::BOX_HALF_Q - tmbcr_pkg::TILE_HALF_Q);
  localparam logic signed [DIFF_W:0] MIN_DIST = (DIFF_W+1)'(tmbcr_pkg::MIN_DIST_Q);

  logic signed [DIFF_W-1:0] dx, dy;
  logic [DIFF_W-1:0]        ax, ay;
  logic signed [DIFF_W:0]   xd, yd;
  logic                     xpos, ypos;
  logic signed [WPOS_W-1:0] mx, my;
  tmbcr_pkg::tmbcr_job_t    c_job;

  logic                     a_v_r, b_v_r, c_v_r;
  tmbcr_pkg::tmbcr_job_t    a_job_r, b_job_r, c_job_r;
  logic signed [DIFF_W-1:0] a_dx_r, a_dy_r;
  logic signed [DIFF_W:0]   b_xd_r, b_yd_r;
  logic                     b_xneg_r, b_yneg_r;

  // box center minus tile center
  always_comb begin
    dx = $signed(DIFF_W'(in_job.px))
       - $signed(DIFF_W'({in_job.col[K], {tmbcr_pkg::TILE_SHIFT{1'b0}}})) + DX_OFS;
    dy = $signed(DIFF_W'(in_job.py))
       - $signed(DIFF_W'({in_job.row[K], {tmbcr_pkg::TILE_SHIFT{1'b0}}})) + DX_OFS;
  end

  // penetration depths
  always_comb begin
    ax = a_dx_r[DIFF_W-1] ? DIFF_W'(-a_dx_r) : DIFF_W'(a_dx_r);
    ay = a_dy_r[DIFF_W-1] ? DIFF_W'(-a_dy_r) : DIFF_W'(a_dy_r);
    xd = MIN_DIST - $signed({1'b0, ax});
    yd = MIN_DIST - $signed({1'b0, ay});
  end

  // push along the shallower axis; ties go along y, zero offset goes positive
  always_comb begin
    xpos  = !b_xd_r[DIFF_W] && (b_xd_r != '0);
    ypos  = !b_yd_r[DIFF_W] && (b_yd_r != '0);
    mx    = WPOS_W'(b_xd_r[DIST_W-1:0]);
    my    = WPOS_W'(b_yd_r[DIST_W-1:0]);
    c_job = b_job_r;
    if (b_job_r.solid[K] && xpos && ypos) begin
      if (b_xd_r < b_yd_r) begin
        c_job.px = b_xneg_r ? b_job_r.px - mx : b_job_r.px + mx;
      end else begin
        c_job.py = b_yneg_r ? b_job_r.py - my : b_job_r.py + my;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_job_r  <= in_job;
      a_dx_r   <= dx;
      a_dy_r   <= dy;
      b_job_r  <= a_job_r;
      b_xd_r   <= xd;
      b_yd_r   <= yd;
      b_xneg_r <= a_dx_r[DIFF_W-1];
      b_yneg_r <= a_dy_r[DIFF_W-1];
      c_job_r  <= c_job;
    end
  end

  assign out_valid = c_v_r;
  assign out_job   = c_job_r;

endmodule

`default_nettype wire

[hdl/tmbcr_back.sv]
// Back end: four push steps in corner order, then saturation to the port
// format. Depends on tmbcr_pkg and tmbcr_push.
`default_nettype none

module tmbcr_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_avail,
  input  tmbcr_pkg::tmbcr_job_t job,
  output logic                  job_take,
  output logic                  res_valid,
  output tmbcr_pkg::tmbcr_out_t res,
  input  logic                  res_ready
);

  localparam int POS_W = tmbcr_pkg::POS_W;

  logic                              en;
  logic [4:0]                        stg_v;
  tmbcr_pkg::tmbcr_job_t [4:0]       stg_job;
  logic signed [tmbcr_pkg::WPOS_W-1:0] sx, sy;

  logic                  res_v_r;
  tmbcr_pkg::tmbcr_out_t res_r;

  // whole pipeline holds only when the finished result cannot leave
  assign en       = !res_v_r || res_ready;
  assign job_take = en && job_avail;

  assign stg_v[0]   = job_avail;
  assign stg_job[0] = job;

  for (genvar k = 0; k < 4; k++) begin : g_step
    tmbcr_push #(.K(k)) u_push (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (stg_v[k]),
      .in_job    (stg_job[k]),
      .out_valid (stg_v[k+1]),
      .out_job   (stg_job[k+1])
    );
  end

  always_comb begin
    if (stg_job[4].px > tmbcr_pkg::WPOS_MAX) begin
      sx = tmbcr_pkg::WPOS_MAX;
    end else if (stg_job[4].px < tmbcr_pkg::WPOS_MIN) begin
      sx = tmbcr_pkg::WPOS_MIN;
    end else begin
      sx = stg_job[4].px;
    end
    if (stg_job[4].py > tmbcr_pkg::WPOS_MAX) begin
      sy = tmbcr_pkg::WPOS_MAX;
    end else if (stg_job[4].py < tmbcr_pkg::WPOS_MIN) begin
      sy = tmbcr_pkg::WPOS_MIN;
    end else begin
      sy = stg_job[4].py;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (en) begin
      res_v_r <= stg_v[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.new_x    <= sx[POS_W-1:0];
      res_r.new_y    <= sy[POS_W-1:0];
      res_r.collided <= |stg_job[4].solid;
    end
  end

  assign res_valid = res_v_r;
  assign res       = res_r;

endmodule

`default_nettype wire

[hdl/tile_map_box_collision_resolve_unit.sv]
// Tile map box collision resolver. Holds a 1-bit-per-tile solidity map
// (MAX_COLS x MAX_ROWS) loaded by write transactions (mode 0) and resolves
// square box positions (mode 1, signed Q15.8, box of 60 px on 64 px tiles).
// The four box corners are looked up, corners on solid tiles inside the
// map_cols x map_rows window are pushed out of in order TL, TR, BL, BR along
// the shallower axis, and the saturated position comes back with a hit flag.
// Write transactions produce no result. Both sides behave as queues: a
// transaction enters when push is high and full is low, and leaves when pop
// is high and empty is low. Throughput is one transaction per clock of
// either kind while full stays low. A result reaches out_data through the
// map read, the front/back queue, the four push steps (three stages each),
// saturation and the result queue. The map sits in four parity banks, so
// all four corner tiles are read together with one port per bank.
// The map is not cleared at reset; tiles must be written before they are
// read. map_cols and map_rows reset to 128 and should be written only while
// no resolve transaction is in flight.
//
// Depends on tmbcr_pkg, tmbcr_front, tmbcr_fifo, tmbcr_push, tmbcr_back.
`default_nettype none

module tile_map_box_collision_resolve_unit #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 128
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input transactions
  input  logic                            push,
  output logic                            full,
  input  tmbcr_pkg::tmbcr_in_t            in_data,
  // results
  output logic                            empty,
  input  logic                            pop,
  output tmbcr_pkg::tmbcr_out_t           out_data,
  // configuration
  input  logic                            cfg_we,
  input  logic [tmbcr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [tmbcr_pkg::CFG_W-1:0]     cfg_data
);

  // front/back decoupling queue and result queue depths
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  logic                  job_valid, mid_can_take, mid_empty, job_take;
  tmbcr_pkg::tmbcr_job_t job, mid_head;
  logic                  res_valid, out_can_take;
  tmbcr_pkg::tmbcr_out_t res;

  // front: accept, map access, corner classification
  tmbcr_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (mid_can_take)
  );

  // classified jobs wait here so front and back stall independently
  tmbcr_fifo #(
    .T     (tmbcr_pkg::tmbcr_job_t),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (job_valid && mid_can_take),
    .wr_data  (job),
    .can_take (mid_can_take),
    .rd_en    (job_take),
    .empty    (mid_empty),
    .rd_data  (mid_head)
  );

  // back: push steps and saturation
  tmbcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_avail (!mid_empty),
    .job       (mid_head),
    .job_take  (job_take),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (out_can_take)
  );

  // result queue, head drives the ports
  tmbcr_fifo #(
    .T     (tmbcr_pkg::tmbcr_out_t),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (res_valid && out_can_take),
    .wr_data  (res),
    .can_take (out_can_take),
    .rd_en    (pop && !empty),
    .empty    (empty),
    .rd_data  (out_data)
  );

endmodule

`default_nettype wire

[hdl/tmbcr_checker.sv]
// Port-level checker for the tile map box collision resolve unit, bound to
// the top level. Depends on tmbcr_pkg and the defines header.
`default_nettype none
`include "tile_map_box_collision_resolve_unit_defines.svh"

module tmbcr_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  full,
  input logic                  empty,
  input logic                  pop,
  input tmbcr_pkg::tmbcr_out_t out_data
);

  // a waiting result stays until taken
  `TMBCR_ASSERT_NEXT(a_result_held, !empty && !pop, !empty, "result dropped before pop")
  `TMBCR_ASSERT_NEXT(a_result_stable, !empty && !pop, $stable(out_data), "result changed before pop")
  // reset leaves both queues idle
  `TMBCR_ASSERT_PLAIN(a_reset_idle, !rst_n |=> (empty && !full), "not idle after reset")
  // pipeline latency rules out a result soon after reset
  `TMBCR_ASSERT_PLAIN(a_no_early_result, (rst_n && $past(!rst_n, 8)) |-> empty, "result too early after reset")

endmodule

bind tile_map_box_collision_resolve_unit tmbcr_checker u_tmbcr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);

`default_nettype wire

[dv/tb.sv]
// Testbench for the tile map box collision resolve unit: a queue-fed driver,
// a result monitor and a cycle-free predictor of the solidity map and pushes.
// Depends on tmbcr_pkg and tile_map_box_collision_resolve_unit.
`timescale 1ns / 1ps

module tb;

  localparam int     POS_W      = tmbcr_pkg::POS_W;
  localparam int     TILE_SHIFT = tmbcr_pkg::TILE_SHIFT;
  localparam int     MAP_DIM    = 128;        // map array is MAP_DIM x MAP_DIM
  localparam int     SETTLE     = 40;         // wait after the last result, in cycles
  localparam longint POS_HI     = 8388607;
  localparam longint POS_LO     = -8388608;
  localparam int     TILE_Q     = 1 << TILE_SHIFT;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  push     = 1'b0;
  logic                  full;
  tmbcr_pkg::tmbcr_in_t  in_data  = '0;
  logic                  empty;
  logic                  pop      = 1'b0;
  tmbcr_pkg::tmbcr_out_t out_data;
  logic                            cfg_we   = 1'b0;
  logic [tmbcr_pkg::CFG_IDX_W-1:0] cfg_idx  = '0;
  logic [tmbcr_pkg::CFG_W-1:0]     cfg_data = '0;

  tile_map_box_collision_resolve_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state: map contents as the block holds them, plus the window
  bit         tile_solid_q [MAP_DIM*MAP_DIM];
  // generator side: tiles that some queued write transaction will have set
  bit         tile_known [MAP_DIM*MAP_DIM];
  logic [7:0] map_cols = tmbcr_pkg::CFG_RESET;
  logic [7:0] map_rows = tmbcr_pkg::CFG_RESET;

  tmbcr_pkg::tmbcr_in_t  pending_items [$];
  tmbcr_pkg::tmbcr_out_t expected_results [$];

  int mismatches = 0;
  bit calm       = 1'b0;   // no idling on either side
  int send_gap   = 0;
  int pop_gap    = 0;

  // Floor tile of corner k (TL, TR, BL, BR). True if it lies in the window.
  // Arithmetic shift on a signed longint gives the floor division directly.
  function automatic bit corner_in_map(input int k, input longint x, input longint y,
                                       output int col, output int row);
    longint cx, cy, c, r, ec, er;
    cx = x + ((k & 1) ? tmbcr_pkg::BOX_Q : 0);
    cy = y + ((k & 2) ? tmbcr_pkg::BOX_Q : 0);
    c  = cx >>> TILE_SHIFT;
    r  = cy >>> TILE_SHIFT;
    ec = (map_cols > MAP_DIM) ? MAP_DIM : map_cols;
    er = (map_rows > MAP_DIM) ? MAP_DIM : map_rows;
    col = int'(c);
    row = int'(r);
    return c >= 0 && c < ec && r >= 0 && r < er;
  endfunction

  function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
    if (v > POS_HI) return POS_W'(POS_HI);
    if (v < POS_LO) return POS_W'(POS_LO);
    return POS_W'(v);
  endfunction

  // Corrected position for one resolve transaction against the current map.
  function automatic tmbcr_pkg::tmbcr_out_t resolve_box(
      input logic signed [POS_W-1:0] pos_x,
      input logic signed [POS_W-1:0] pos_y);
    longint                x, y, dx, dy, xd, yd;
    int                    hit_col [4];
    int                    hit_row [4];
    int                    n, c, r;
    tmbcr_pkg::tmbcr_out_t res;
    x = pos_x;
    y = pos_y;
    n = 0;
    // solid corner tiles in corner order, duplicates kept
    for (int k = 0; k < 4; k++) begin
      if (corner_in_map(k, x, y, c, r) && tile_solid_q[r*MAP_DIM + c]) begin
        hit_col[n] = c;
        hit_row[n] = r;
        n++;
      end
    end
    // push out of each tile along the shallower axis; ties go along y,
    // zero offset pushes positive
    for (int i = 0; i < n; i++) begin
      dx = (x + tmbcr_pkg::BOX_HALF_Q)
         - ((longint'(hit_col[i]) <<< TILE_SHIFT) + tmbcr_pkg::TILE_HALF_Q);
      dy = (y + tmbcr_pkg::BOX_HALF_Q)
         - ((longint'(hit_row[i]) <<< TILE_SHIFT) + tmbcr_pkg::TILE_HALF_Q);
      xd = tmbcr_pkg::MIN_DIST_Q - ((dx < 0) ? -dx : dx);
      yd = tmbcr_pkg::MIN_DIST_Q - ((dy < 0) ? -dy : dy);
      if (xd > 0 && yd > 0) begin
        if (xd < yd) x = (dx < 0) ? x - xd : x + xd;
        else         y = (dy < 0) ? y - yd : y + yd;
      end
    end
    res.new_x    = clamp_pos(x);
    res.new_y    = clamp_pos(y);
    res.collided = (n > 0);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building. Items go on pending_items in order; a resolve is
  // preceded by writes for any in-window corner tile not yet loaded, so the
  // block never reads an unwritten map entry.
  // ---------------------------------------------------------------------------
  task automatic queue_write(input int col, input int row, input bit solid);
    tmbcr_pkg::tmbcr_in_t it;
    it.mode       = tmbcr_pkg::MODE_WRITE;
    it.tile_col   = 7'(col);
    it.tile_row   = 7'(row);
    it.tile_solid = solid;
    it.pos_x      = POS_W'($urandom);   // ignored by a write
    it.pos_y      = POS_W'($urandom);
    pending_items = {pending_items, it};
    tile_known[row*MAP_DIM + col] = 1'b1;
  endtask

  task automatic queue_resolve(input logic signed [POS_W-1:0] px,
                               input logic signed [POS_W-1:0] py);
    tmbcr_pkg::tmbcr_in_t it;
    int                   c, r;
    for (int k = 0; k < 4; k++) begin
      if (corner_in_map(k, px, py, c, r) && !tile_known[r*MAP_DIM + c])
        queue_write(c, r, $urandom_range(0, 99) < 45);
    end
    it.mode       = tmbcr_pkg::MODE_RESOLVE;
    it.tile_col   = 7'($urandom);       // ignored by a resolve
    it.tile_row   = 7'($urandom);
    it.tile_solid = 1'($urandom);
    it.pos_x      = px;
    it.pos_y      = py;
    pending_items = {pending_items, it};
  endtask

  // Coordinate from one tile before the window to one tile past it; a
  // quarter of them sit on whole pixels to hit exact tile boundaries.
  function automatic logic signed [POS_W-1:0] near_window(input int span);
    int t, off;
    t   = int'($urandom_range(0, span + 1)) - 1;
    off = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 63)) << 8
                                      : int'($urandom_range(0, TILE_Q - 1));
    return POS_W'(t * TILE_Q + off);
  endfunction

  task automatic queue_random(input int count);
    int eff_c, eff_r, pick;
    for (int i = 0; i < count; i++) begin
      eff_c = (map_cols > MAP_DIM) ? MAP_DIM : ((map_cols == 0) ? 4 : map_cols);
      eff_r = (map_rows > MAP_DIM) ? MAP_DIM : ((map_rows == 0) ? 4 : map_rows);
      pick  = $urandom_range(0, 99);
      if (pick < 25)
        queue_write($urandom_range(0, 1) ? $urandom_range(0, MAP_DIM - 1)
                                         : $urandom_range(0, eff_c - 1),
                    $urandom_range(0, 1) ? $urandom_range(0, MAP_DIM - 1)
                                         : $urandom_range(0, eff_r - 1),
                    $urandom_range(0, 99) < 45);
      else if (pick < 32)
        queue_resolve(POS_W'($urandom), POS_W'($urandom));   // anywhere at all
      else
        queue_resolve(near_window(eff_c), near_window(eff_r));
    end
  endtask

  // Register writes go in only here, with the block idle.
  task automatic write_reg(input logic [tmbcr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
    if (idx == tmbcr_pkg::CFG_MAP_COLS) map_cols = val;
    else                                map_rows = val;
  endtask

  // Sender pauses here until every expected result is back, then lets any
  // trailing write transactions clear the pipeline.
  task automatic drain_results();
    while (pending_items.size() != 0 || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] cols, input logic [7:0] rows, input int count);
    write_reg(tmbcr_pkg::CFG_MAP_COLS, cols);
    write_reg(tmbcr_pkg::CFG_MAP_ROWS, rows);
    queue_random(count);
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: presents pending_items[0] at the falling edge unless in an
  // idle burst. The item stays on the port until the acceptance block pops it.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (send_gap > 0) send_gap--;
    else if (!calm && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 18);
    if (rst_n && send_gap == 0 && pending_items.size() != 0) begin
      push    <= 1'b1;
      in_data <= pending_items[0];
    end else begin
      push    <= 1'b0;
    end
  end

  // Accepted transaction: update the map model or record the expected result.
  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      pending_items.delete(0);
      if (in_data.mode == tmbcr_pkg::MODE_WRITE)
        tile_solid_q[in_data.tile_row*MAP_DIM + in_data.tile_col] = in_data.tile_solid;
      else
        expected_results = {expected_results, resolve_box(in_data.pos_x, in_data.pos_y)};
    end
  end

  // Result side: pop stalls in random bursts.
  always @(negedge clk) begin
    if (pop_gap > 0) pop_gap--;
    else if (!calm && $urandom_range(0, 9) == 0) pop_gap = $urandom_range(1, 18);
    pop <= rst_n && pop_gap == 0;
  end

  task automatic report_mismatch(input string field, input logic signed [POS_W-1:0] want,
                                 input logic signed [POS_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
  endtask

  always @(posedge clk) begin : check_result
    tmbcr_pkg::tmbcr_out_t want;
    if (rst_n && pop && !empty) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no transaction pending, x=%0d y=%0d hit=%0b",
                   $realtime, out_data.new_x, out_data.new_y, out_data.collided);
      end else begin
        want = expected_results.pop_front();
        if (out_data.new_x !== want.new_x)
          report_mismatch("new_x", want.new_x, out_data.new_x);
        if (out_data.new_y !== want.new_y)
          report_mismatch("new_y", want.new_y, out_data.new_y);
        if (out_data.collided !== want.collided)
          report_mismatch("collided", POS_W'(want.collided), POS_W'(out_data.collided));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed transactions on the reset window, then random
  // phases across window settings including zero, one, full and oversized.
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    tmbcr_pkg::tmbcr_in_t probe;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // write transactions with all fields high and all fields low
    probe = '1;
    probe.mode = tmbcr_pkg::MODE_WRITE;
    pending_items = {pending_items, probe};
    tile_known[MAP_DIM*MAP_DIM - 1] = 1'b1;
    probe = '0;
    pending_items = {pending_items, probe};
    tile_known[0] = 1'b1;
    // position extremes, far outside the map
    queue_resolve(24'h7FFFFF, 24'h7FFFFF);
    queue_resolve(24'h800000, 24'h800000);
    queue_resolve(24'h7FFFFF, 24'h800000);
    // last map tile, other corners past the window edge
    queue_resolve(POS_W'((127*64 + 10) * 256), POS_W'((127*64 + 10) * 256));
    // box centered on a solid tile: four duplicate corners, equal depths,
    // zero offset, so the first push goes down
    queue_write(1, 1, 1'b1);
    queue_resolve(POS_W'(66*256), POS_W'(66*256));
    // equal depths with a positive offset
    queue_resolve(POS_W'(71*256), POS_W'(71*256));
    // right edge exactly on a solid tile's left edge: hit without a move
    queue_write(0, 1, 1'b0);
    queue_resolve(POS_W'(4*256), POS_W'(66*256));
    // left corners at a negative column, pushed left off tile 0,0
    queue_write(0, 0, 1'b1);
    queue_resolve(POS_W'(-10*256), POS_W'(0));
    queue_resolve(POS_W'(40*256), POS_W'(50*256));
    queue_resolve(POS_W'(90*256), POS_W'(40*256));
    drain_results();

    run_phase(8'd1,   8'd1,   100);
    run_phase(8'd0,   8'd6,    60);
    run_phase(8'd255, 8'd255,  60);
    run_phase(8'd129, 8'd3,    60);
    run_phase(8'd9,   8'd7,   250);
    run_phase(8'd128, 8'd0,    50);
    calm = 1'b1;   // final stretch runs at full rate on both sides
    run_phase(8'd128, 8'd128, 130);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hard stop, far above the slowest legal run
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
